>>> rtl/gcd_pkg.sv
// Shared constants, types and table builders for the great-circle distance pipeline.
// Depends on nothing; every other rtl file imports it.
`default_nettype none

package gcd_pkg;

    // Field and datapath widths
    localparam int LAT_W     = 32;
    localparam int LON_W     = 33;
    localparam int ANG_W     = 34;
    localparam int RADIUS_W  = 23;
    localparam int DIST_W    = 35;
    localparam int ROOT_W    = 61;
    localparam int Q_FRAC    = 60;
    localparam int MUL_LAT   = 3;
    localparam int MAX_STAGES = 40;

    // Defaults for the top level parameters
    localparam int DEF_ANGLE_FRAC_BITS = 24;
    localparam int DEF_CORDIC_STAGES   = 32;

    // Q60 and Q62 constants, and the reset radius
    localparam logic [63:0] ONE_Q60        = 64'h1000_0000_0000_0000;
    localparam logic [63:0] PI_Q60         = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] HALF_PI_Q60    = PI_Q60 >> 1;
    localparam logic [63:0] PI_Q62         = 64'hC90F_DAA2_2168_C234;
    localparam logic [63:0] DEG_TO_RAD_Q62 = PI_Q62 / 64'd180;
    localparam logic [63:0] GAIN_Q60       = 64'h9B74_EDA8 << 28;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

    typedef logic [MAX_STAGES-1:0][63:0] t_atan_rom;

    // One arctangent entry, Q60, from the alternating series
    function automatic logic [63:0] atan_entry(input int unsigned idx);
        logic [63:0] s;
        logic [63:0] term;
        int unsigned k;
        int unsigned odd;
        int unsigned sh;
        s = '0;
        if (idx == 0) return PI_Q60 >> 2;
        if (idx > 62) return '0;
        for (k = 0; idx * (2 * k + 1) <= 62; k++) begin
            odd  = 2 * k + 1;
            sh   = 62 - idx * odd;
            term = (64'd1 << sh) / 64'(odd);
            if (k[0]) s = s - term;
            else s = s + term;
        end
        return s >> 2;
    endfunction

    // Whole arctangent table, built at elaboration
    function automatic t_atan_rom atan_table();
        t_atan_rom t;
        for (int i = 0; i < MAX_STAGES; i++) begin
            t[i] = atan_entry(i);
        end
        return t;
    endfunction

    // Smallest k with (full << k) covering the magnitude of an in_w-bit signed angle
    function automatic int mod_shift(input logic [63:0] full, input int in_w);
        int k;
        k = 0;
        while ((full << k) < (64'd1 << (in_w - 1))) k++;
        return k;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gcd_mul.sv
// Pipelined 64 x 64 unsigned multiplier built from four 32 x 32 partial products.
// Depends on gcd_pkg for the latency constant.
`default_nettype none

module gcd_mul import gcd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_vld,
    output logic [127:0] o_prod
);

    logic [63:0] r_p00, r_p01, r_p10, r_p11;
    logic [63:0] r_lo, r_hi;
    logic [64:0] r_mid;
    logic [MUL_LAT-1:0] r_vld;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[MUL_LAT-2:0], i_vld};
        end
    end

    // Partial products, middle sum, final sum
    always_ff @(posedge i_clk) begin
        r_p00  <= i_a[31:0]  * i_b[31:0];
        r_p01  <= i_a[31:0]  * i_b[63:32];
        r_p10  <= i_a[63:32] * i_b[31:0];
        r_p11  <= i_a[63:32] * i_b[63:32];
        r_lo   <= r_p00;
        r_hi   <= r_p11;
        r_mid  <= {1'b0, r_p01} + {1'b0, r_p10};
        o_prod <= {r_hi, 64'd0} + {31'd0, r_mid, 32'd0} + {64'd0, r_lo};
    end

    assign o_vld = r_vld[MUL_LAT-1];

endmodule

`default_nettype wire

>>> rtl/gcd_cos.sv
// Cosine of a fixed-point degree angle: range reduction, fold, radian scaling, CORDIC rotation.
// Depends on gcd_pkg and gcd_mul.
`default_nettype none

module gcd_cos import gcd_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic signed [ANG_W-1:0] i_ang,
    output logic                    o_vld,
    output logic signed [63:0]      o_cos
);

    localparam logic [63:0] FULL  = 64'd360 << ANGLE_FRAC_BITS;
    localparam logic [63:0] HALF  = FULL >> 1;
    localparam logic [63:0] QUART = FULL >> 2;
    localparam int          K     = mod_shift(FULL, ANG_W);
    localparam int          STEPS = K + 1;
    localparam logic [63:0] TOP   = FULL << STEPS;
    localparam int          V_W   = $clog2(TOP) + 1;
    localparam int          R_W   = $clog2(QUART + 64'd1);
    localparam logic [63:0] OFF   = FULL << K;
    localparam t_atan_rom   ATAN  = atan_table();
    localparam int          S     = CORDIC_STAGES;

    logic [V_W-1:0] r_v [STEPS+1];
    logic [V_W-1:0] n_v [STEPS+1];
    logic [STEPS:0] r_vv;

    logic [R_W-1:0] r_r;
    logic           r_fneg;
    logic           r_fvld;
    logic [V_W-1:0] w_f1;
    logic [V_W-1:0] w_f2;
    logic           w_fneg;

    logic           w_mvld;
    logic [127:0]   w_prod;
    logic [MUL_LAT-1:0] r_nd;

    logic signed [63:0] r_cx [S+1];
    logic signed [63:0] r_cy [S+1];
    logic signed [63:0] r_cz [S+1];
    logic signed [63:0] n_cx [S+1];
    logic signed [63:0] n_cy [S+1];
    logic signed [63:0] n_cz [S+1];
    logic [S:0]         r_cn;
    logic [S:0]         r_cv;

    // Reduce modulo a full turn, one conditional subtract per stage
    always_comb begin
        logic [63:0] step;
        n_v[0] = r_v[0];
        for (int s = 1; s <= STEPS; s++) begin
            step = FULL << (STEPS - s);
            if (r_v[s-1] >= V_W'(step)) n_v[s] = r_v[s-1] - V_W'(step);
            else n_v[s] = r_v[s-1];
        end
    end

    // Fold into the first quadrant, note the sign flip
    always_comb begin
        w_f1   = (r_v[STEPS] > V_W'(HALF)) ? V_W'(FULL) - r_v[STEPS] : r_v[STEPS];
        w_fneg = w_f1 > V_W'(QUART);
        w_f2   = w_fneg ? V_W'(HALF) - w_f1 : w_f1;
    end

    // Rotation iterations
    always_comb begin
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        n_cx[0] = r_cx[0];
        n_cy[0] = r_cy[0];
        n_cz[0] = r_cz[0];
        for (int g = 0; g < S; g++) begin
            xs = r_cx[g] >>> g;
            ys = r_cy[g] >>> g;
            if (!r_cz[g][63]) begin
                n_cx[g+1] = r_cx[g] - ys;
                n_cy[g+1] = r_cy[g] + xs;
                n_cz[g+1] = r_cz[g] - signed'(ATAN[g]);
            end else begin
                n_cx[g+1] = r_cx[g] + ys;
                n_cy[g+1] = r_cy[g] - xs;
                n_cz[g+1] = r_cz[g] + signed'(ATAN[g]);
            end
        end
    end

    gcd_mul u_rad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_fvld),
        .i_a     (64'(r_r)),
        .i_b     (DEG_TO_RAD_Q62),
        .o_vld   (w_mvld),
        .o_prod  (w_prod)
    );

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv   <= '0;
            r_fvld <= 1'b0;
            r_cv   <= '0;
            o_vld  <= 1'b0;
        end else begin
            r_vv   <= {r_vv[STEPS-1:0], i_vld};
            r_fvld <= r_vv[STEPS];
            r_cv   <= {r_cv[S-1:0], w_mvld};
            o_vld  <= r_cv[S];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_v[0] <= {{(V_W-ANG_W){i_ang[ANG_W-1]}}, i_ang} + V_W'(OFF);
        for (int s = 1; s <= STEPS; s++) begin
            r_v[s] <= n_v[s];
        end
        r_r    <= w_f2[R_W-1:0];
        r_fneg <= w_fneg;
        r_nd   <= {r_nd[MUL_LAT-2:0], r_fneg};
        r_cx[0] <= signed'(GAIN_Q60);
        r_cy[0] <= '0;
        r_cz[0] <= signed'(w_prod[ANGLE_FRAC_BITS+2 +: 64]);
        r_cn    <= {r_cn[S-1:0], r_nd[MUL_LAT-1]};
        for (int g = 1; g <= S; g++) begin
            r_cx[g] <= n_cx[g];
            r_cy[g] <= n_cy[g];
            r_cz[g] <= n_cz[g];
        end
        o_cos <= r_cn[S] ? -r_cx[S] : r_cx[S];
    end

endmodule

`default_nettype wire

>>> rtl/gcd_sqrt.sv
// Pipelined square root of a Q60 value, one result bit per stage.
// Depends on gcd_pkg.
`default_nettype none

module gcd_sqrt import gcd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [ROOT_W-1:0] i_v,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root
);

    localparam int REM_W = 65;

    logic [REM_W-1:0]  r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];
    logic [ROOT_W:0]   r_sv   [ROOT_W+1];
    logic [REM_W-1:0]  n_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] n_root [ROOT_W+1];
    logic [ROOT_W:0]   r_vld;

    // One restoring step per stage; radicand is v shifted up by Q_FRAC
    always_comb begin
        int i;
        logic [1:0]       pair;
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] trial;
        n_rem[0]  = r_rem[0];
        n_root[0] = r_root[0];
        for (int g = 0; g < ROOT_W; g++) begin
            i = ROOT_W - 1 - g;
            if (2 * i >= Q_FRAC) pair = r_sv[g][2*i-Q_FRAC +: 2];
            else pair = 2'b00;
            sh    = {r_rem[g][REM_W-3:0], pair};
            trial = {2'b00, r_root[g], 2'b01};
            if (sh >= trial) begin
                n_rem[g+1]  = sh - trial;
                n_root[g+1] = {r_root[g][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[g+1]  = sh;
                n_root[g+1] = {r_root[g][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ROOT_W-1:0], i_vld};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_sv[0]   <= {1'b0, i_v};
        for (int g = 1; g <= ROOT_W; g++) begin
            r_rem[g]  <= n_rem[g];
            r_root[g] <= n_root[g];
            r_sv[g]   <= r_sv[g-1];
        end
    end

    assign o_vld  = r_vld[ROOT_W];
    assign o_root = r_root[ROOT_W];

endmodule

`default_nettype wire

>>> rtl/gcd_vec.sv
// Arcsine by CORDIC vectoring of (sqrt(1-a), sqrt(a)), then scaling by the
// diameter in millimetres with rounding and half-circumference saturation.
// Depends on gcd_pkg and gcd_mul.
`default_nettype none

module gcd_vec import gcd_pkg::*; #(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [ROOT_W-1:0]   i_x,
    input  logic [ROOT_W-1:0]   i_y,
    input  logic [RADIUS_W-1:0] i_radius,
    output logic                o_vld,
    output logic [DIST_W-1:0]   o_dist
);

    localparam t_atan_rom ATAN = atan_table();
    localparam int        S    = CORDIC_STAGES;
    localparam logic [127:0] ROUND = 128'd1 << (Q_FRAC - 1);

    logic signed [63:0] r_x [S+1];
    logic signed [63:0] r_y [S+1];
    logic signed [63:0] r_z [S+1];
    logic signed [63:0] n_x [S+1];
    logic signed [63:0] n_y [S+1];
    logic signed [63:0] n_z [S+1];
    logic [S:0]         r_v;

    logic [ROOT_W-1:0] r_zc;
    logic              r_zv;
    logic [32:0]       r_scale;
    logic              w_dv;
    logic [127:0]      w_dp;
    logic [127:0]      w_hp;
    logic [67:0]       r_d;
    logic [67:0]       r_half;
    logic              r_dv;
    logic [67:0]       w_sat;

    // Vectoring iterations
    always_comb begin
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        n_x[0] = r_x[0];
        n_y[0] = r_y[0];
        n_z[0] = r_z[0];
        for (int g = 0; g < S; g++) begin
            xs = r_x[g] >>> g;
            ys = r_y[g] >>> g;
            if (!r_y[g][63]) begin
                n_x[g+1] = r_x[g] + ys;
                n_y[g+1] = r_y[g] - xs;
                n_z[g+1] = r_z[g] + signed'(ATAN[g]);
            end else begin
                n_x[g+1] = r_x[g] - ys;
                n_y[g+1] = r_y[g] + xs;
                n_z[g+1] = r_z[g] - signed'(ATAN[g]);
            end
        end
    end

    gcd_mul u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_zv),
        .i_a     (64'(r_zc)),
        .i_b     ({30'd0, r_scale, 1'b0}),
        .o_vld   (w_dv),
        .o_prod  (w_dp)
    );

    // Half circumference follows the radius register continuously
    gcd_mul u_half (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (1'b1),
        .i_a     (PI_Q60),
        .i_b     (64'(r_scale)),
        .o_vld   (),
        .o_prod  (w_hp)
    );

    assign w_sat = (r_d > r_half) ? r_half : r_d;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_zv  <= 1'b0;
            r_dv  <= 1'b0;
            o_vld <= 1'b0;
        end else begin
            r_v   <= {r_v[S-1:0], i_vld};
            r_zv  <= r_v[S];
            r_dv  <= w_dv;
            o_vld <= r_dv;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_x[0] <= signed'(64'(i_x));
        r_y[0] <= signed'(64'(i_y));
        r_z[0] <= '0;
        for (int g = 1; g <= S; g++) begin
            r_x[g] <= n_x[g];
            r_y[g] <= n_y[g];
            r_z[g] <= n_z[g];
        end
        // Clamp the angle into [0, pi/2]
        if (r_z[S][63]) r_zc <= '0;
        else if (r_z[S] > signed'(HALF_PI_Q60)) r_zc <= HALF_PI_Q60[ROOT_W-1:0];
        else r_zc <= r_z[S][ROOT_W-1:0];
        r_scale <= {10'd0, i_radius} * 33'd1000;
        r_d     <= 68'((w_dp + ROUND) >> Q_FRAC);
        r_half  <= 68'((w_hp + ROUND) >> Q_FRAC);
        o_dist  <= w_sat[DIST_W-1:0];
    end

endmodule

`default_nettype wire

>>> rtl/great_circle_distance.sv
// Haversine great-circle distance between two points in fixed-point degrees.
//
// Command channel: a point pair is taken at each rising edge with start high and
// busy low. busy is always low: the datapath is a fully pipelined chain and takes
// one pair every cycle.
// Result channel: o_valid marks o_distance_mm for exactly one cycle; the receiver
// cannot hold it off and none is needed, since the pipeline never stalls.
// The latency is set by the two chained CORDIC pipelines, the K+1 modulo-360
// subtract stages in each cosine unit (K = 1 at 24 angle fraction bits) and
// the 61-stage square-root units.
// Configuration: i_cfg_valid with i_cfg_data writes the earth radius in metres;
// o_cfg_ready is always high. Write it only while no pair is in flight.
// Reset (synchronous, active low) clears all in-flight valid bits and loads the
// radius with 6371000 m. Results are rounded to the nearest millimetre and
// saturate at half the circumference.
// Depends on gcd_pkg, gcd_mul, gcd_cos, gcd_sqrt and gcd_vec.
`default_nettype none

module great_circle_distance import gcd_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [LAT_W-1:0] i_from_lat,
    input  logic signed [LON_W-1:0] i_from_lon,
    input  logic signed [LAT_W-1:0] i_to_lat,
    input  logic signed [LON_W-1:0] i_to_lon,
    output logic                    o_valid,
    output logic [DIST_W-1:0]       o_distance_mm,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [RADIUS_W-1:0]     i_cfg_data
);

    logic [RADIUS_W-1:0] r_radius;

    logic                    r_in_vld;
    logic signed [ANG_W-1:0] r_dlat, r_dlon, r_lat1, r_lat2;

    logic               w_cv_dlat, w_cv_lat1, w_cv_lat2, w_cv_dlon;
    logic signed [63:0] w_c_dlat, w_c_lat1, w_c_lat2, w_c_dlon;

    logic               r_h_vld;
    logic signed [63:0] r_t1, r_t3;
    logic               r_s12;
    logic [63:0]        r_m1, r_m2;

    logic               w_p1_vld;
    logic [127:0]       w_p1;
    logic signed [63:0] r_t1_d1 [MUL_LAT];
    logic signed [63:0] r_t3_d  [MUL_LAT];
    logic [MUL_LAT-1:0] r_s12_d;

    logic               r_p_vld;
    logic [63:0]        r_pm;
    logic               r_neg2;
    logic signed [63:0] r_pt1, r_pt3;

    logic               w_p2_vld;
    logic [127:0]       w_p2;
    logic signed [63:0] r_t1_d2 [MUL_LAT];
    logic [MUL_LAT-1:0] r_neg2_d;

    logic               r_a_vld;
    logic [ROOT_W-1:0]  r_a, r_oma;
    logic signed [63:0] w_sum;
    logic [63:0]        w_pmag;

    logic               w_sx_vld, w_sy_vld;
    logic [ROOT_W-1:0]  w_root_x, w_root_y;

    // Half versine: (1 - c) / 2 clamped to [0, 1]
    function automatic logic signed [63:0] half_vers(input logic signed [63:0] c);
        logic signed [63:0] h;
        h = (signed'(ONE_Q60) - c) >>> 1;
        if (h < 0) return '0;
        if (h > signed'(ONE_Q60)) return signed'(ONE_Q60);
        return h;
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_radius <= i_cfg_data;
        end
    end

    // Capture a beat and form the angle differences
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lat1 <= {{(ANG_W-LAT_W){i_from_lat[LAT_W-1]}}, i_from_lat};
        r_lat2 <= {{(ANG_W-LAT_W){i_to_lat[LAT_W-1]}}, i_to_lat};
        r_dlat <= {{(ANG_W-LAT_W){i_to_lat[LAT_W-1]}}, i_to_lat}
                - {{(ANG_W-LAT_W){i_from_lat[LAT_W-1]}}, i_from_lat};
        r_dlon <= {{(ANG_W-LON_W){i_to_lon[LON_W-1]}}, i_to_lon}
                - {{(ANG_W-LON_W){i_from_lon[LON_W-1]}}, i_from_lon};
    end

    gcd_cos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cos_dlat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_in_vld), .i_ang(r_dlat),
        .o_vld(w_cv_dlat), .o_cos(w_c_dlat)
    );
    gcd_cos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cos_lat1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_in_vld), .i_ang(r_lat1),
        .o_vld(w_cv_lat1), .o_cos(w_c_lat1)
    );
    gcd_cos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cos_lat2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_in_vld), .i_ang(r_lat2),
        .o_vld(w_cv_lat2), .o_cos(w_c_lat2)
    );
    gcd_cos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cos_dlon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_in_vld), .i_ang(r_dlon),
        .o_vld(w_cv_dlon), .o_cos(w_c_dlon)
    );

    // Half versines and magnitudes for cos(lat1) * cos(lat2)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= w_cv_dlat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1  <= half_vers(w_c_dlat);
        r_t3  <= half_vers(w_c_dlon);
        r_s12 <= w_c_lat1[63] ^ w_c_lat2[63];
        r_m1  <= mag(w_c_lat1);
        r_m2  <= mag(w_c_lat2);
    end

    gcd_mul u_mul_cc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_h_vld), .i_a(r_m1), .i_b(r_m2),
        .o_vld(w_p1_vld), .o_prod(w_p1)
    );

    // Hold side terms alongside the first product
    always_ff @(posedge i_clk) begin
        r_t1_d1[0] <= r_t1;
        r_t3_d[0]  <= r_t3;
        r_s12_d    <= {r_s12_d[MUL_LAT-2:0], r_s12};
        for (int i = 1; i < MUL_LAT; i++) begin
            r_t1_d1[i] <= r_t1_d1[i-1];
            r_t3_d[i]  <= r_t3_d[i-1];
        end
    end

    // Truncate the product and set up the second multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= w_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pm   <= w_p1[Q_FRAC +: 64];
        r_neg2 <= r_s12_d[MUL_LAT-1] && (w_p1[Q_FRAC +: 64] != 64'd0);
        r_pt1  <= r_t1_d1[MUL_LAT-1];
        r_pt3  <= r_t3_d[MUL_LAT-1];
    end

    gcd_mul u_mul_ct (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_p_vld), .i_a(r_pm), .i_b(64'(r_pt3)),
        .o_vld(w_p2_vld), .o_prod(w_p2)
    );

    always_ff @(posedge i_clk) begin
        r_t1_d2[0] <= r_pt1;
        r_neg2_d   <= {r_neg2_d[MUL_LAT-2:0], r_neg2};
        for (int i = 1; i < MUL_LAT; i++) begin
            r_t1_d2[i] <= r_t1_d2[i-1];
        end
    end

    // Sum the haversine term and clamp to [0, 1]
    assign w_pmag = w_p2[Q_FRAC +: 64];
    assign w_sum  = r_t1_d2[MUL_LAT-1]
                  + (r_neg2_d[MUL_LAT-1] ? -signed'(w_pmag) : signed'(w_pmag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sum[63]) begin
            r_a   <= '0;
            r_oma <= ONE_Q60[ROOT_W-1:0];
        end else if (w_sum > signed'(ONE_Q60)) begin
            r_a   <= ONE_Q60[ROOT_W-1:0];
            r_oma <= '0;
        end else begin
            r_a   <= w_sum[ROOT_W-1:0];
            r_oma <= ONE_Q60[ROOT_W-1:0] - w_sum[ROOT_W-1:0];
        end
    end

    gcd_sqrt u_sqrt_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_a_vld), .i_v(r_oma),
        .o_vld(w_sx_vld), .o_root(w_root_x)
    );
    gcd_sqrt u_sqrt_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_a_vld), .i_v(r_a),
        .o_vld(w_sy_vld), .o_root(w_root_y)
    );

    gcd_vec #(.CORDIC_STAGES(CORDIC_STAGES)) u_vec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_sx_vld),
        .i_x      (w_root_x),
        .i_y      (w_root_y),
        .i_radius (r_radius),
        .o_vld    (o_valid),
        .o_dist   (o_distance_mm)
    );

    // The four cosine units run in lockstep
    a_cos_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cv_dlat == w_cv_lat1) && (w_cv_dlat == w_cv_lat2) && (w_cv_dlat == w_cv_dlon))
        else $error("cosine units out of step");

    // Both square-root units run in lockstep
    a_sqrt_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sx_vld == w_sy_vld)
        else $error("square-root units out of step");

    // Roots of values in [0, 1] stay within one
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sx_vld |-> (w_root_x <= ONE_Q60[ROOT_W-1:0]) && (w_root_y <= ONE_Q60[ROOT_W-1:0]))
        else $error("square root above one");

    // Reset drops every result in flight
    a_rst_flush: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

endmodule

`default_nettype wire
